>>> hw/rtl/a2c_pkg.sv
// a2c_pkg: shared constants, fixed-point formats and the divider word type
// for the cubic atan2 approximation; no dependencies
package a2c_pkg;

  // number widths
  localparam int QuoW     = 16;   // quotient of the ratio divider, 0..32768
  localparam int RemW     = 18;   // partial remainder, always below the divisor
  localparam int DvsW     = 18;   // divisor 2*den, up to 131072
  localparam int LowW     = 16;   // low dividend bits fed into the cells
  localparam int DivCells = QuoW; // one cell per quotient bit

  // coefficients in Q1.15
  localparam int CoefA   = 6432;  // 0.1963
  localparam int CoefB   = 32168; // 0.9817
  localparam int OneQ15  = 32768;

  // angles in Q3.13
  localparam int QtrPi   = 6434;
  localparam int TqtrPi  = 19302;
  localparam int PiQ13   = 25736;

  // word handed from cell to cell along the divider chain
  typedef struct packed {
    logic [RemW-1:0] rem;      // partial remainder
    logic [DvsW-1:0] dvs;      // divisor, 2*den
    logic [LowW-1:0] n_low;    // dividend bits not yet brought down
    logic [QuoW-1:0] quo;      // quotient bits so far
    logic            neg_r;    // ratio is negative
    logic            den_zero; // both inputs zero, ratio forced to -1
    logic            x_neg;    // selects the 3*pi/4 base
    logic            y_neg;    // result is negated
  } a2c_div_t;

endpackage

>>> hw/rtl/a2c_pre.sv
// a2c_pre: input stage, forms magnitudes, ratio numerator and divisor
// depends on a2c_pkg
module a2c_pre (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   y_value,
  input  logic signed [15:0]   x_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output a2c_pkg::a2c_div_t    out_word
);
  import a2c_pkg::*;

  logic        y_neg;
  logic        x_neg;
  logic [16:0] ay;
  logic [16:0] ax;
  logic [16:0] den;
  logic [16:0] mag;
  logic        neg_r;
  a2c_div_t    word_next;
  logic        vld;

  assign y_neg = y_value[15];
  assign x_neg = x_value[15];
  assign ay    = y_neg ? (17'd0 - {y_value[15], y_value}) : {y_value[15], y_value};
  assign ax    = x_neg ? (17'd0 - {x_value[15], x_value}) : {x_value[15], x_value};

  // den = |x| + |y| in both half planes, num = +-(|x| - |y|)
  assign den   = ax + ay;
  assign mag   = (ax >= ay) ? (ax - ay) : (ay - ax);
  assign neg_r = x_neg ? (ay < ax) : (ax < ay);

  always_comb begin
    word_next.rem      = RemW'(mag) + RemW'(den[16]);
    word_next.dvs      = {den, 1'b0};
    word_next.n_low    = den[LowW-1:0];
    word_next.quo      = '0;
    word_next.neg_r    = neg_r;
    word_next.den_zero = (den == 17'd0);
    word_next.x_neg    = x_neg;
    word_next.y_neg    = y_neg;
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

>>> hw/rtl/a2c_div_cell.sv
// a2c_div_cell: one restoring-division cell, resolves one quotient bit
// depends on a2c_pkg
module a2c_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  a2c_pkg::a2c_div_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output a2c_pkg::a2c_div_t out_word
);
  import a2c_pkg::*;

  logic [RemW:0] shifted;
  logic [RemW:0] diff;
  logic          ge;
  a2c_div_t      word_next;
  logic          vld;

  assign shifted = {in_word.rem, in_word.n_low[LowW-1]};
  assign diff    = shifted - {1'b0, in_word.dvs};
  assign ge      = (shifted >= {1'b0, in_word.dvs});

  always_comb begin
    word_next       = in_word;
    word_next.rem   = ge ? diff[RemW-1:0] : shifted[RemW-1:0];
    word_next.n_low = {in_word.n_low[LowW-2:0], 1'b0};
    word_next.quo   = {in_word.quo[QuoW-2:0], ge};
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

>>> hw/rtl/a2c_post.sv
// a2c_post: cubic correction, base angle, sign and saturation, four stages
// depends on a2c_pkg
module a2c_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  a2c_pkg::a2c_div_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] angle_rad
);
  import a2c_pkg::*;

  logic [3:0] vld;
  logic [3:0] rdy;

  // stage 1 registers
  logic [QuoW-1:0] s1_q;
  logic [15:0]     s1_r2q;
  logic            s1_neg;
  logic            s1_xn;
  logic            s1_yn;
  // stage 2 registers
  logic [QuoW-1:0] s2_q;
  logic [14:0]     s2_pm;
  logic            s2_neg;
  logic            s2_xn;
  logic            s2_yn;
  // stage 3 registers
  logic [12:0]     s3_tm;
  logic            s3_neg;
  logic            s3_xn;
  logic            s3_yn;

  logic [QuoW-1:0]    qe;
  logic [31:0]        sq;
  logic [28:0]        prod_a;
  logic [12:0]        ar;
  logic [15:0]        pm_full;
  logic [30:0]        prod_t;
  logic [15:0]        base;
  logic signed [16:0] sum;
  logic signed [16:0] signed_sum;
  logic signed [16:0] sat;

  // ready ripples back from the output register
  assign rdy[3]    = !vld[3] || out_ready;
  assign rdy[2]    = !vld[2] || rdy[3];
  assign rdy[1]    = !vld[1] || rdy[2];
  assign rdy[0]    = !vld[0] || rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  // stage 1: |r| squared, rounded to Q1.15
  assign qe = in_word.den_zero ? QuoW'(OneQ15) : in_word.quo;
  assign sq = 32'(qe) * 32'(qe);

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      s1_q   <= qe;
      s1_r2q <= 16'((sq + 32'd16384) >> 15);
      s1_neg <= in_word.den_zero | in_word.neg_r;
      s1_xn  <= in_word.x_neg;
      s1_yn  <= in_word.y_neg;
    end
  end

  // stage 2: magnitude of A*r^2 - B, always negative
  assign prod_a  = 29'(CoefA) * 29'(s1_r2q);
  assign ar      = 13'((prod_a + 29'd16384) >> 15);
  assign pm_full = 16'(CoefB) - 16'(ar);

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      s2_q   <= s1_q;
      s2_pm  <= pm_full[14:0];
      s2_neg <= s1_neg;
      s2_xn  <= s1_xn;
      s2_yn  <= s1_yn;
    end
  end

  // stage 3: magnitude of the cubic term, rounded to Q3.13
  assign prod_t = 31'(s2_pm) * 31'(s2_q);

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      s3_tm  <= 13'((prod_t + 31'd65536) >> 17);
      s3_neg <= s2_neg;
      s3_xn  <= s2_xn;
      s3_yn  <= s2_yn;
    end
  end

  // stage 4: term is positive for negative r, then sign and clamp
  assign base       = s3_xn ? 16'(TqtrPi) : 16'(QtrPi);
  assign sum        = s3_neg ? ($signed({1'b0, base}) + $signed({4'b0, s3_tm}))
                             : ($signed({1'b0, base}) - $signed({4'b0, s3_tm}));
  assign signed_sum = s3_yn ? -sum : sum;

  always_comb begin
    priority if (signed_sum > 17'(PiQ13)) begin
      sat = 17'(PiQ13);
    end else if (signed_sum < -17'(PiQ13)) begin
      sat = -17'(PiQ13);
    end else begin
      sat = signed_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      angle_rad <= sat[15:0];
    end
  end

endmodule

>>> hw/rtl/atan2_cubic_approx.sv
// atan2_cubic_approx: top level, approximate four-quadrant arctangent
// depends on a2c_pkg, a2c_pre, a2c_div_cell, a2c_post
//
//  channel   handshake             payload
//  in        in_valid / in_ready   y_value, x_value  (signed 16 each)
//  out       out_valid / out_ready angle_rad         (signed Q3.13, +-pi)
//
// one request per cycle sustained while the output is not stalled; the path runs
// through the pre stage for magnitudes and divisor, 16 division cells (one quotient
// bit each), then the post stages for the cubic term, sign and clamp
// every stage holds its own valid bit, so bubbles close up under stall and
// a stalled result does not stop requests until all stages are full
// synchronous reset clears only the valid bits; the data registers are not reset
module atan2_cubic_approx (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] y_value,
  input  logic signed [15:0] x_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] angle_rad
);
  import a2c_pkg::*;

  // chain links: index 0 is the pre stage output, index DivCells the last cell
  logic     chain_valid [DivCells+1];
  logic     chain_ready [DivCells+1];
  a2c_div_t chain_word  [DivCells+1];

  // front stage: |x|, |y|, numerator magnitude and divisor 2*(|x|+|y|)
  a2c_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .y_value   (y_value),
    .x_value   (x_value),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_word  (chain_word[0])
  );

  // row of restoring-division cells: r = round(|num| * 2^15 / den)
  for (genvar i = 0; i < DivCells; i++) begin : g_cell
    a2c_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  // polynomial, base angle, sign of y and clamp to +-pi
  a2c_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[DivCells]),
    .in_ready  (chain_ready[DivCells]),
    .in_word   (chain_word[DivCells]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_rad (angle_rad)
  );

endmodule

>>> hw/rtl/a2c_checker.sv
// a2c_checker: port-level checks on the atan2 block, bound to the top level
// depends on atan2_cubic_approx ports only
module a2c_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] y_value,
  input logic signed [15:0] x_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] angle_rad
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_rad))
    else $error("result changed while stalled");

  // results stay within plus or minus pi
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_rad <= 16'sd25736) && (angle_rad >= -16'sd25736))
    else $error("angle out of range");

  // an empty output register means the pipeline can take a request
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind atan2_cubic_approx a2c_checker u_a2c_checker (.*);

>>> tb/sv/tb_atan2_cubic_approx.sv
`timescale 1ns / 100ps
// tb_atan2_cubic_approx: self-checking testbench for the cubic atan2 block
// depends on a2c_pkg (angle and coefficient constants) and atan2_cubic_approx
module tb_atan2_cubic_approx;
  import a2c_pkg::*;

  localparam int DrainCycles = 40;   // idle cycles after the last result, longer than the pipeline

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] y_value;
  logic signed [15:0] x_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] angle_rad;

  // one accepted request and the angle it must produce
  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] angle;
  } angle_request_t;

  angle_request_t pending_angles[$];
  int             error_count   = 0;
  int             sender_idle   = 0;  // percent of cycles the sender holds off
  int             receiver_idle = 0;  // percent of cycles out_ready stays low

  atan2_cubic_approx DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .y_value  (y_value),
    .x_value  (x_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .angle_rad(angle_rad)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  // shift right by s, rounding half away from zero
  function automatic longint round_half_away(input longint v, input int s);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q   = (mag + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] predict_angle(input logic signed [15:0] y,
                                                       input logic signed [15:0] x);
    int     yi, xi, ay, num, den, base, angle;
    longint ratio, mag, quo, r_sq, poly, term;
    yi = y;
    xi = x;
    ay = (yi < 0) ? -yi : yi;
    // left half plane folds around 3*pi/4, right half around pi/4
    if (xi < 0) begin
      num  = xi + ay;
      den  = ay - xi;
      base = TqtrPi;
    end else begin
      num  = xi - ay;
      den  = xi + ay;
      base = QtrPi;
    end
    // origin has no ratio, pin it to -1 so the answer lands near pi/2
    if (den == 0) begin
      ratio = -OneQ15;
    end else begin
      mag = (num < 0) ? -num : num;
      quo = (mag * 65536 + den) / (2 * den);
      if (quo > OneQ15) quo = OneQ15;
      ratio = (num < 0) ? -quo : quo;
    end
    r_sq  = round_half_away(ratio * ratio, 15);
    poly  = round_half_away(CoefA * r_sq, 15) - CoefB;
    term  = round_half_away(poly * ratio, 17);
    angle = base + int'(term);
    if (yi < 0) angle = -angle;
    if (angle > PiQ13) angle = PiQ13;
    if (angle < -PiQ13) angle = -PiQ13;
    return angle[15:0];
  endfunction

  // ------------------------------------------------------------------ checking

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // receiver side: random stalls at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle);
    end
  end

  // every result taken is matched to the oldest outstanding request
  always @(posedge clk) begin
    angle_request_t req;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("result angle_rad=%0d with no request outstanding",
                                  angle_rad));
      end else begin
        req = pending_angles.pop_front();
        if (angle_rad !== req.angle) begin
          report_mismatch($sformatf("y=%0d x=%0d angle_rad got %0d expected %0d",
                                    req.y, req.x, angle_rad, req.angle));
        end
      end
    end
  end

  // ------------------------------------------------------------------ stimulus

  // called and returns at a falling edge
  task automatic send_request(input logic signed [15:0] y, input logic signed [15:0] x);
    angle_request_t req;
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    y_value  <= y;
    x_value  <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    req.y     = y;
    req.x     = x;
    req.angle = predict_angle(y, x);
    pending_angles.push_back(req);
    @(negedge clk);
  endtask

  // full-range pairs, with a good share of small values, axes, diagonals and extremes
  task automatic random_pair(output logic signed [15:0] y, output logic signed [15:0] x);
    int kind;
    kind = $urandom_range(0, 99);
    y    = 16'($urandom);
    x    = 16'($urandom);
    if (kind < 12) begin
      y = 16'(int'($urandom_range(0, 16)) - 8);
      x = 16'(int'($urandom_range(0, 16)) - 8);
    end else if (kind < 20) begin
      y = 16'sd0;
    end else if (kind < 28) begin
      x = 16'sd0;
    end else if (kind < 40) begin
      // equal magnitudes, any quadrant
      y = $urandom_range(0, 1) ? x : -x;
    end else if (kind < 52) begin
      if ($urandom_range(0, 1)) y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      else                      x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end else if (kind < 60) begin
      // nearly on an axis: large ratio of magnitudes
      y = 16'(int'($urandom_range(0, 6)) - 3);
    end
  endtask

  task automatic random_requests(input int count);
    logic signed [15:0] y, x;
    repeat (count) begin
      random_pair(y, x);
      send_request(y, x);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // origin, axes, diagonals and the most negative codes
  task automatic test_directed_corners();
    sender_idle   = 0;
    receiver_idle = 0;
    send_request(16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd1);
    send_request(16'sd0, -16'sd1);
    send_request(16'sd0, 16'sh7fff);
    send_request(16'sd0, 16'sh8000);
    send_request(16'sd1, 16'sd0);
    send_request(-16'sd1, 16'sd0);
    send_request(16'sh7fff, 16'sd0);
    send_request(16'sh8000, 16'sd0);
    send_request(16'sh7fff, 16'sh7fff);
    send_request(16'sh8000, 16'sh8000);
    send_request(16'sh7fff, 16'sh8000);
    send_request(16'sh8000, 16'sh7fff);
    send_request(16'sd1, 16'sd1);
    send_request(-16'sd1, -16'sd1);
    send_request(16'sd1, -16'sd1);
    send_request(-16'sd1, 16'sd1);
    send_request(16'sd1, 16'sh7fff);
    send_request(-16'sd1, 16'sh8000);
    send_request(16'sd1, 16'sh8000);
    send_request(16'sh8000, -16'sd1);
    send_request(16'sh7fff, 16'sd1);
    send_request(16'sh5555, 16'shaaaa);
    send_request(16'shaaaa, 16'sh5555);
    wait_for_drain();
  endtask

  // results back up: receiver mostly stalled, pipeline fills
  task automatic test_output_backpressure();
    sender_idle   = 7;
    receiver_idle = 82;
    random_requests(410);
    wait_for_drain();
  endtask

  // requests trickle in, pipeline runs mostly empty
  task automatic test_sparse_requests();
    sender_idle   = 82;
    receiver_idle = 7;
    random_requests(410);
    wait_for_drain();
  endtask

  // back-to-back requests and results, one per cycle
  task automatic test_full_rate();
    sender_idle   = 0;
    receiver_idle = 0;
    random_requests(410);
    wait_for_drain();
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    y_value  = 16'sd0;
    x_value  = 16'sd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_corners();
    test_output_backpressure();
    test_sparse_requests();
    test_full_rate();
    if (error_count == 0) begin
      $display("tb_atan2_cubic_approx: PASS");
    end else begin
      $display("tb_atan2_cubic_approx: FAIL");
    end
    $finish;
  end

  // watchdog timeout, many times the slowest correct run
  initial begin
    #2000000;
    $display("tb_atan2_cubic_approx: FAIL");
    $finish;
  end

endmodule
